// File: rtl/icc_pkg.sv
// icc_pkg: shared types, register indexes and helpers for the isometric
// camera clamp and projection block. No dependencies.
package icc_pkg;

    // Width of the working arithmetic inside the limit logic
    localparam int unsigned CALC_W = 21;
    // Width of the projection products before the divide by 256
    localparam int unsigned PROD_W = 28;

    localparam int unsigned POS_W   = 16;
    localparam int unsigned CONF_W  = 19;
    localparam int unsigned VIEW_W  = 18;
    localparam int unsigned INDEX_W = 3;

    // Limit modes
    typedef enum logic [1:0] {
        MODE_PASS = 2'd0,
        MODE_BOX  = 2'd1,
        MODE_DIAG = 2'd2
    } t_mode;

    // Configuration register indexes
    typedef enum logic [INDEX_W-1:0] {
        REG_BOUND_MODE  = 3'd0,
        REG_FIRST_LOW   = 3'd1,
        REG_SECOND_LOW  = 3'd2,
        REG_FIRST_HIGH  = 3'd3,
        REG_SECOND_HIGH = 3'd4
    } t_reg_index;

    // Limit settings
    typedef struct packed {
        logic [1:0]               mode;
        logic signed [POS_W-1:0]  first_low;
        logic signed [POS_W-1:0]  second_low;
        logic signed [POS_W-1:0]  first_high;
        logic signed [POS_W-1:0]  second_high;
    } t_cfg;

    // World position as it arrives
    typedef struct packed {
        logic signed [POS_W-1:0] z;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] x;
    } t_pos;

    // Position after the limits
    typedef struct packed {
        logic signed [CONF_W-1:0] z;
        logic signed [POS_W-1:0]  y;
        logic signed [CONF_W-1:0] x;
    } t_conf_pos;

    // Projected view coordinates
    typedef struct packed {
        logic signed [VIEW_W-1:0] vz;
        logic signed [VIEW_W-1:0] vy;
        logic signed [VIEW_W-1:0] vx;
    } t_view;

    // Signed divide by 256, rounding toward zero
    function automatic logic signed [PROD_W-1:0] trunc_div256(
        input logic signed [PROD_W-1:0] v
    );
        logic signed [PROD_W-1:0] biased;
        biased = v + (v[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
        return biased >>> 8;
    endfunction

endpackage

// File: rtl/icc_clamp.sv
// icc_clamp: combinational camera limit logic (pass, axis box, diagonals).
// Depends on icc_pkg.
module icc_clamp (
    input  icc_pkg::t_cfg      i_cfg,
    input  icc_pkg::t_pos      i_pos,
    output icc_pkg::t_conf_pos o_pos
);

    logic signed [icc_pkg::CALC_W-1:0] x, y, z, h, u, w, v, d;
    logic signed [icc_pkg::CALC_W-1:0] fl, fh, sl, sh;

    always_comb begin
        x  = icc_pkg::CALC_W'(i_pos.x);
        y  = icc_pkg::CALC_W'(i_pos.y);
        z  = icc_pkg::CALC_W'(i_pos.z);
        fl = icc_pkg::CALC_W'(i_cfg.first_low);
        fh = icc_pkg::CALC_W'(i_cfg.first_high);
        sl = icc_pkg::CALC_W'(i_cfg.second_low);
        sh = icc_pkg::CALC_W'(i_cfg.second_high);
        h  = y >>> 1;
        u  = x - h;
        w  = z - h;
        v  = '0;
        d  = '0;
        unique case (i_cfg.mode)
            icc_pkg::MODE_BOX: begin
                // low test wins when limits cross
                if (u < fl) begin
                    u = fl;
                end else if (u > fh) begin
                    u = fh;
                end
                if (w < sl) begin
                    w = sl;
                end else if (w > sh) begin
                    w = sh;
                end
                x = u + h;
                z = w + h;
            end
            icc_pkg::MODE_DIAG: begin
                // first diagonal: z - x
                v = z - x;
                if (v < fl) begin
                    d = (fl - v) >>> 1;
                    x = x - d;
                    z = z + d;
                end else if (v > fh) begin
                    d = (v - fh) >>> 1;
                    x = x + d;
                    z = z - d;
                end
                // second diagonal: z + x - y, from updated x and z
                v = z + x - y;
                if (v < sl) begin
                    d = (sl - v) >>> 1;
                    x = x + d;
                    z = z + d;
                end else if (v > sh) begin
                    d = (v - sh) >>> 1;
                    x = x - d;
                    z = z - d;
                end
            end
            default: begin
                // pass through, unused code too
            end
        endcase
        o_pos.x = x[icc_pkg::CONF_W-1:0];
        o_pos.z = z[icc_pkg::CONF_W-1:0];
        o_pos.y = i_pos.y;
    end

endmodule

// File: rtl/icc_proj.sv
// icc_proj: combinational isometric projection of a confined position.
// Depends on icc_pkg.
module icc_proj (
    input  icc_pkg::t_conf_pos i_pos,
    output icc_pkg::t_view     o_view
);

    logic signed [icc_pkg::PROD_W-1:0] hx, hz, a, b, px, pd, py, tx;

    always_comb begin
        hx = icc_pkg::PROD_W'(i_pos.x) >>> 1;
        hz = icc_pkg::PROD_W'(i_pos.z) >>> 1;
        // constant multiplies as shift-add
        px = ((hx - hz) <<< 5) + ((hx - hz) <<< 4);
        pd = ((hx + hz) <<< 5) + ((hx + hz) <<< 4);
        py = (icc_pkg::PROD_W'(i_pos.y) <<< 4) + (icc_pkg::PROD_W'(i_pos.y) <<< 3);
        a  = icc_pkg::trunc_div256(pd);
        b  = icc_pkg::trunc_div256(py);
        tx = icc_pkg::trunc_div256(px);
        o_view.vx = tx[icc_pkg::VIEW_W-1:0];
        o_view.vy = icc_pkg::VIEW_W'(a - b);
        o_view.vz = icc_pkg::VIEW_W'(a + b);
    end

endmodule

// File: rtl/isometric_camera_clamp_project.sv
// isometric_camera_clamp_project: top level, stream ports, limit registers
// and a three-register pipeline. Depends on icc_pkg, icc_clamp, icc_proj.
//
//  channel   | direction | handshake                    | payload
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | pos_x, pos_y, pos_z
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | out_x,out_z,view_x/y/z
//  cfg       | in        | i_cfg_wr_en (no wait)        | index, data
//
// One request per cycle sustained while the output is not stalled; registers in
// order: input register, limit register, result register. Limits sit before
// the middle register, projection before the result register.
// Reset (synchronous, i_rst_n low) empties the pipeline and clears all
// limit registers to zero. A stalled output holds each full stage; the
// input is refused only when every stage is full and the output is stalled.
module isometric_camera_clamp_project (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // pos_x[15:0], pos_y[31:16], pos_z[47:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_x[18:0], out_z[37:19], view_x[55:38], view_y[73:56], view_z[91:74], zero
    output logic [95:0] m_axis_tdata,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);

    icc_pkg::t_cfg      r_cfg;
    icc_pkg::t_pos      r_s1_pos;
    icc_pkg::t_conf_pos r_s2_pos;
    icc_pkg::t_conf_pos r_out_pos;
    icc_pkg::t_view     r_out_view;
    logic               r_s1_valid, r_s2_valid, r_out_valid;

    icc_pkg::t_conf_pos n_s2_pos;
    icc_pkg::t_view     n_out_view;
    logic               out_adv, s2_adv, s1_adv, in_fire;

    // Limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                icc_pkg::REG_BOUND_MODE:  r_cfg.mode        <= i_cfg_wdata[1:0];
                icc_pkg::REG_FIRST_LOW:   r_cfg.first_low   <= i_cfg_wdata;
                icc_pkg::REG_SECOND_LOW:  r_cfg.second_low  <= i_cfg_wdata;
                icc_pkg::REG_FIRST_HIGH:  r_cfg.first_high  <= i_cfg_wdata;
                icc_pkg::REG_SECOND_HIGH: r_cfg.second_high <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Stage advance chain
    assign out_adv       = !r_out_valid || m_axis_tready;
    assign s2_adv        = !r_s2_valid || out_adv;
    assign s1_adv        = !r_s1_valid || s2_adv;
    assign s_axis_tready = s1_adv;
    assign in_fire       = s_axis_tvalid && s1_adv;

    icc_clamp u_clamp (
        .i_cfg (r_cfg),
        .i_pos (r_s1_pos),
        .o_pos (n_s2_pos)
    );

    icc_proj u_proj (
        .i_pos  (r_s2_pos),
        .o_view (n_out_view)
    );

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (s2_adv) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_pos <= s_axis_tdata;
        end
        if (s2_adv && r_s1_valid) begin
            r_s2_pos <= n_s2_pos;
        end
        if (out_adv && r_s2_valid) begin
            r_out_pos  <= r_s2_pos;
            r_out_view <= n_out_view;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_view.vz, r_out_view.vy, r_out_view.vx,
                            r_out_pos.z, r_out_pos.x};

    // An accepted request always lands in the input stage
    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_s1_valid)
        else $error("accepted request lost at input stage");

    // A full middle stage that cannot move keeps its request
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !s2_adv) |=> r_s2_valid)
        else $error("middle stage dropped a stalled request");

    // Empty pipeline never refuses input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_s1_valid && !r_s2_valid && !r_out_valid) |-> s_axis_tready)
        else $error("empty pipeline refused input");

    // Height passes through the limit stage unchanged
    a_height_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_adv && r_s1_valid) |=> (r_s2_pos.y == $past(r_s1_pos.y)))
        else $error("height altered by limit logic");

endmodule

// File: tb/icc_view_checker.sv
`timescale 1ns / 100ps
// icc_view_checker: watches the position, result and limit ports of the isometric
// camera block, predicts every view result and compares it. Depends on icc_pkg.
module icc_view_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [47:0] i_in_data,    // pos_x, pos_y, pos_z
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [95:0] i_out_data,   // out_x, out_z, view_x, view_y, view_z, zero
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    output int          o_pending,
    output int          o_mismatches
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [icc_pkg::CONF_W-1:0] out_x;
        logic signed [icc_pkg::CONF_W-1:0] out_z;
        logic signed [icc_pkg::VIEW_W-1:0] view_x;
        logic signed [icc_pkg::VIEW_W-1:0] view_y;
        logic signed [icc_pkg::VIEW_W-1:0] view_z;
    } t_view_result;

    // Shadow of the limit registers
    logic [1:0] lim_mode   = icc_pkg::MODE_PASS;
    int         first_lo   = 0;
    int         second_lo  = 0;
    int         first_hi   = 0;
    int         second_hi  = 0;

    t_view_result pending_views[$];
    int           mismatch_count = 0;

    // Confine one position to the current limits, then project it
    function automatic t_view_result project_position(input logic [47:0] pos);
        int x, y, z, h, u, w, v, d, hx, hz, a, b;
        t_view_result r;
        x = int'($signed(pos[15:0]));
        y = int'($signed(pos[31:16]));
        z = int'($signed(pos[47:32]));
        case (lim_mode)
            icc_pkg::MODE_BOX: begin
                h = y >>> 1;
                u = x - h;
                w = z - h;
                // low test first; high test only when not below
                if (u < first_lo) u = first_lo;
                else if (u > first_hi) u = first_hi;
                if (w < second_lo) w = second_lo;
                else if (w > second_hi) w = second_hi;
                x = u + h;
                z = w + h;
            end
            icc_pkg::MODE_DIAG: begin
                v = z - x;
                if (v < first_lo) begin
                    d = (first_lo - v) >>> 1;
                    x -= d;
                    z += d;
                end else if (v > first_hi) begin
                    d = (v - first_hi) >>> 1;
                    x += d;
                    z -= d;
                end
                // second diagonal works on the updated point
                v = z + x - y;
                if (v < second_lo) begin
                    d = (second_lo - v) >>> 1;
                    x += d;
                    z += d;
                end else if (v > second_hi) begin
                    d = (v - second_hi) >>> 1;
                    x -= d;
                    z -= d;
                end
            end
            default: ;  // pass-through, unused mode included
        endcase
        hx = x >>> 1;
        hz = z >>> 1;
        // int divide truncates toward zero
        a = ((hx + hz) * 48) / 256;
        b = (y * 24) / 256;
        r.out_x  = icc_pkg::CONF_W'(x);
        r.out_z  = icc_pkg::CONF_W'(z);
        r.view_x = icc_pkg::VIEW_W'(((hx - hz) * 48) / 256);
        r.view_y = icc_pkg::VIEW_W'(a - b);
        r.view_z = icc_pkg::VIEW_W'(a + b);
        return r;
    endfunction

    // Track writes, queue predictions, compare results
    always @(posedge i_clk) begin
        t_view_result seen;
        t_view_result want;
        if (!i_rst_n) begin
            lim_mode  = icc_pkg::MODE_PASS;
            first_lo  = 0;
            second_lo = 0;
            first_hi  = 0;
            second_hi = 0;
            pending_views.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    icc_pkg::REG_BOUND_MODE:  lim_mode  = i_cfg_wdata[1:0];
                    icc_pkg::REG_FIRST_LOW:   first_lo  = int'($signed(i_cfg_wdata));
                    icc_pkg::REG_SECOND_LOW:  second_lo = int'($signed(i_cfg_wdata));
                    icc_pkg::REG_FIRST_HIGH:  first_hi  = int'($signed(i_cfg_wdata));
                    icc_pkg::REG_SECOND_HIGH: second_hi = int'($signed(i_cfg_wdata));
                    default: ;  // unknown index ignored
                endcase
            end
            if (i_in_valid && i_in_ready)
                pending_views.push_back(project_position(i_in_data));
            if (i_out_valid && i_out_ready) begin
                seen.out_x  = i_out_data[18:0];
                seen.out_z  = i_out_data[37:19];
                seen.view_x = i_out_data[55:38];
                seen.view_y = i_out_data[73:56];
                seen.view_z = i_out_data[91:74];
                if (pending_views.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: result with no request waiting: x=%0d z=%0d",
                                 $time, seen.out_x, seen.out_z);
                end else begin
                    want = pending_views.pop_front();
                    if (seen.out_x !== want.out_x || seen.out_z !== want.out_z ||
                        seen.view_x !== want.view_x || seen.view_y !== want.view_y ||
                        seen.view_z !== want.view_z) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("%0t: mismatch exp x=%0d z=%0d vx=%0d vy=%0d vz=%0d",
                                     $time, want.out_x, want.out_z, want.view_x,
                                     want.view_y, want.view_z);
                            $display("%0t:          got x=%0d z=%0d vx=%0d vy=%0d vz=%0d",
                                     $time, seen.out_x, seen.out_z, seen.view_x,
                                     seen.view_y, seen.view_z);
                        end
                    end
                end
            end
        end
        o_pending    <= pending_views.size();
        o_mismatches <= mismatch_count;
    end

endmodule

// File: tb/isometric_camera_clamp_project_tb.sv
`timescale 1ns / 100ps
// isometric_camera_clamp_project_tb: drives positions and limit settings into
// the block and gives the verdict. Depends on icc_pkg, the block, icc_view_checker.
module isometric_camera_clamp_project_tb;

    localparam int PIPE_LAT      = 3;
    localparam int SETTLE_CYCLES = PIPE_LAT + 4;
    localparam int NUM_PHASES    = 14;
    localparam int PHASE_ITEMS   = 125;
    localparam int IDLE_PCT      = 23;
    localparam int HOLD_CYCLES   = 80;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;   // pos_x[15:0], pos_y[31:16], pos_z[47:32]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // out_x[18:0], out_z[37:19], view_x[55:38], view_y[73:56], view_z[91:74], zero
    logic [95:0] m_axis_tdata;
    logic        i_cfg_wr_en   = 1'b0;
    logic [2:0]  i_cfg_index   = '0;
    logic [15:0] i_cfg_wdata   = '0;

    int pending;
    int mismatches;

    // Flow control shared with the receiver process
    bit idle_en       = 1'b1;
    int hold_requests = 0;

    always #10 i_clk = ~i_clk;

    isometric_camera_clamp_project dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    icc_view_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    // Result side: random stalls, plus a long hold-off on request
    initial begin : result_flow
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(idle_en && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Offer one position; returns just after the edge that took it
    task automatic offer_position(input logic [47:0] pos);
        bit taken;
        while (idle_en && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pos;
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // Stop offering and wait until every predicted result is out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_limits(input logic [1:0] mode, input logic [15:0] f_lo,
                                input logic [15:0] s_lo, input logic [15:0] f_hi,
                                input logic [15:0] s_hi);
        write_reg(icc_pkg::REG_BOUND_MODE, 16'(mode));
        write_reg(icc_pkg::REG_FIRST_LOW, f_lo);
        write_reg(icc_pkg::REG_SECOND_LOW, s_lo);
        write_reg(icc_pkg::REG_FIRST_HIGH, f_hi);
        write_reg(icc_pkg::REG_SECOND_HIGH, s_hi);
    endtask

    // Mix of full range, near zero, near the extremes and mid-size values
    function automatic logic [15:0] rand_coord();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'(int'($urandom_range(16)) - 8);
            2: return $urandom_range(1) ? 16'(32767 - int'($urandom_range(3)))
                                        : 16'(-32768 + int'($urandom_range(3)));
            default: return 16'(int'($urandom_range(4000)) - 2000);
        endcase
    endfunction

    // Stimulus: phases of limit settings, each followed by positions
    initial begin : stimulus
        logic [15:0] cx, cy, cz;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            idle_en = 1'b1;
            case (ph)
                0: ;  // reset values: pass-through, all limits zero
                1: apply_limits(icc_pkg::MODE_BOX, 16'(-500), 16'(-300), 16'(700),
                                16'(400));
                2: apply_limits(icc_pkg::MODE_DIAG, 16'(-800), 16'(-1000), 16'(600),
                                16'(900));
                3: apply_limits(icc_pkg::MODE_BOX, 16'h8000, 16'h8000, 16'h7FFF,
                                16'h7FFF);
                // crossed limits: low test wins
                4: apply_limits(icc_pkg::MODE_DIAG, 16'h7FFF, 16'(100), 16'h8000,
                                16'(-100));
                5: begin
                    apply_limits(icc_pkg::MODE_BOX, 16'(100), 16'h7FFF, 16'(-100),
                                 16'h8000);
                    hold_requests++;
                end
                6: begin
                    apply_limits(icc_pkg::MODE_DIAG, 16'h8000, 16'h8000, 16'h7FFF,
                                 16'h7FFF);
                    idle_en = 1'b0;
                end
                7: begin
                    apply_limits(MODE_UNUSED, rand_coord(), rand_coord(), rand_coord(),
                                 rand_coord());
                    write_reg(3'(int'(icc_pkg::REG_SECOND_HIGH) + 1 + $urandom_range(2)),
                              16'($urandom));
                end
                8: apply_limits(icc_pkg::MODE_BOX, 16'd0, 16'd0, 16'd0, 16'd0);
                9: apply_limits(icc_pkg::MODE_DIAG, 16'd0, 16'd0, 16'd0, 16'd0);
                10: apply_limits(icc_pkg::MODE_PASS, rand_coord(), rand_coord(),
                                 rand_coord(), rand_coord());
                default: begin
                    write_reg(3'(int'(icc_pkg::REG_SECOND_HIGH) + 1 + $urandom_range(2)),
                              16'($urandom));
                    apply_limits(2'($urandom_range(3)), rand_coord(), rand_coord(),
                                 rand_coord(), rand_coord());
                end
            endcase

            // corner positions under pass, box and diagonal limits
            if (ph < 3) begin
                for (int c = 0; c < 8; c++) begin
                    cx = c[0] ? 16'h7FFF : 16'h8000;
                    cy = c[1] ? 16'h7FFF : 16'h8000;
                    cz = c[2] ? 16'h7FFF : 16'h8000;
                    offer_position({cz, cy, cx});
                end
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // sender pause until the pipeline is empty
                if (ph == 9 && n == PHASE_ITEMS / 2)
                    drain_results();
                offer_position({rand_coord(), rand_coord(), rand_coord()});
            end
        end

        drain_results();
        if (mismatches == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/icc_pkg.sv
rtl/icc_clamp.sv
rtl/icc_proj.sv
rtl/isometric_camera_clamp_project.sv
tb/icc_view_checker.sv
tb/isometric_camera_clamp_project_tb.sv
